>>> rtl/core/hash_dereplicate_aggregator_macros.svh
// ---------------------------------------------------------------------------
// hash dereplicate aggregator assertion macros
// shared property shorthands for the checker
// ---------------------------------------------------------------------------
`ifndef HASH_DEREPLICATE_AGGREGATOR_MACROS_SVH
`define HASH_DEREPLICATE_AGGREGATOR_MACROS_SVH

// same-cycle implication, reset masked
`define HDA_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define HDA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hda_pkg.sv
// ---------------------------------------------------------------------------
// hda_pkg
// shared types and constants of the hash dereplicate aggregator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hda_pkg;

  // sizing
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int MIN_INDEX_BITS  = 4;
  localparam int MAX_INDEX_BITS  = 12;
  localparam int INDEX_W         = 4;
  localparam int SLOT_W          = 12;
  localparam int GROUPS_W        = 13;
  localparam logic [INDEX_W-1:0] INDEX_BITS_RESET = 4'd12;

  // one bucket of the store
  typedef struct packed {
    logic        valid;
    logic [63:0] key_hash;
    logic [31:0] first_number;
    logic [31:0] last_number;
    logic [63:0] mass;
    logic [31:0] size_count;
    logic [31:0] singles;
  } bucket_t;

  // incoming item
  typedef struct packed {
    logic [63:0] key_hash;
    logic [31:0] item_number;
    logic [31:0] item_weight;
  } item_t;

  // result of one item
  typedef struct packed {
    logic [SLOT_W-1:0]   slot_index;
    logic                opened_new;
    logic                link_valid;
    logic [31:0]         link_source;
    logic [31:0]         leader_number;
    logic [31:0]         member_count;
    logic [63:0]         total_weight;
    logic [31:0]         single_count;
    logic [GROUPS_W-1:0] groups_open;
    logic [63:0]         heaviest_weight;
    logic [31:0]         largest_count;
    logic                table_full;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/hda_if.sv
// ---------------------------------------------------------------------------
// hda channel interfaces
// valid/ready channels for configuration, items and results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// configuration write channel
interface hda_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index_bits;

  modport source (output valid, output index_bits, input ready);
  modport sink   (input valid, input index_bits, output ready);
endinterface

// item channel
interface hda_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_hash;
  logic [31:0] item_number;
  logic [31:0] item_weight;

  modport source (output valid, output key_hash, output item_number,
                  output item_weight, input ready);
  modport sink   (input valid, input key_hash, input item_number,
                  input item_weight, output ready);
endinterface

// result channel
interface hda_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] slot_index;
  logic        opened_new;
  logic        link_valid;
  logic [31:0] link_source;
  logic [31:0] leader_number;
  logic [31:0] member_count;
  logic [63:0] total_weight;
  logic [31:0] single_count;
  logic [12:0] groups_open;
  logic [63:0] heaviest_weight;
  logic [31:0] largest_count;
  logic        table_full;

  modport source (output valid, output slot_index, output opened_new,
                  output link_valid, output link_source, output leader_number,
                  output member_count, output total_weight, output single_count,
                  output groups_open, output heaviest_weight,
                  output largest_count, output table_full, input ready);
  modport sink   (input valid, input slot_index, input opened_new,
                  input link_valid, input link_source, input leader_number,
                  input member_count, input total_weight, input single_count,
                  input groups_open, input heaviest_weight,
                  input largest_count, input table_full, output ready);
endinterface

`default_nettype wire

>>> rtl/core/hash_dereplicate_aggregator.sv
// ---------------------------------------------------------------------------
// hash_dereplicate_aggregator
// linear probing bucket store that merges items with equal hash into clusters
// ---------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  cfg_i    | in  | valid/ready  | index_bits (active size, log2)
//  in_i     | in  | valid/ready  | key_hash, item_number, item_weight
//  out_o    | out | valid/ready  | slot, link, cluster totals, maxima, full
//
//  an item is probed bucket by bucket until a free or matching one is found,
//  then updated and finished before the next item is accepted; one bucket
//  read per cycle on the store's single read port sets the probe loop. a
//  full table drops the item once all buckets are probed. after reset a
//  clearing sweep writes every bucket, in_i not ready; cfg writes are always
//  taken. a held result in out_o stalls only the next item's finish state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hash_dereplicate_aggregator #(
  parameter int TABLE_DEPTH = hda_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hda_cfg_if.sink    cfg_i,
  hda_in_if.sink     in_i,
  hda_out_if.source  out_o
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [hda_pkg::INDEX_W-1:0] index_bits_q;
  hda_pkg::item_t              in_item;
  hda_pkg::result_t            res;
  logic                        ram_wr_en;
  logic [ADDR_W-1:0]           ram_wr_addr;
  hda_pkg::bucket_t            ram_wr_data;
  logic                        ram_rd_en;
  logic [ADDR_W-1:0]           ram_rd_addr;
  hda_pkg::bucket_t            ram_rd_data;

  // configuration register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q <= hda_pkg::INDEX_BITS_RESET;
    end else if (cfg_i.valid) begin
      index_bits_q <= cfg_i.index_bits;
    end
  end

  // item payload
  assign in_item.key_hash    = in_i.key_hash;
  assign in_item.item_number = in_i.item_number;
  assign in_item.item_weight = in_i.item_weight;

  hda_probe_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .index_bits_i  (index_bits_q),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .in_item_i     (in_item),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_data_o    (res)
  );

  hda_bucket_ram #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // result payload
  assign out_o.slot_index      = res.slot_index;
  assign out_o.opened_new      = res.opened_new;
  assign out_o.link_valid      = res.link_valid;
  assign out_o.link_source     = res.link_source;
  assign out_o.leader_number   = res.leader_number;
  assign out_o.member_count    = res.member_count;
  assign out_o.total_weight    = res.total_weight;
  assign out_o.single_count    = res.single_count;
  assign out_o.groups_open     = res.groups_open;
  assign out_o.heaviest_weight = res.heaviest_weight;
  assign out_o.largest_count   = res.largest_count;
  assign out_o.table_full      = res.table_full;

endmodule

`default_nettype wire

>>> rtl/core/hda_bucket_ram.sv
// ---------------------------------------------------------------------------
// hda_bucket_ram
// bucket store: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hda_bucket_ram #(
  parameter int TABLE_DEPTH = hda_pkg::TABLE_DEPTH_DEF,
  localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 wr_en_i,
  input  wire logic [ADDR_W-1:0]    wr_addr_i,
  input  wire hda_pkg::bucket_t     wr_data_i,
  input  wire logic                 rd_en_i,
  input  wire logic [ADDR_W-1:0]    rd_addr_i,
  output hda_pkg::bucket_t          rd_data_o
);

  hda_pkg::bucket_t mem_q [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hda_probe_ctrl.sv
// ---------------------------------------------------------------------------
// hda_probe_ctrl
// clearing sweep, linear probe, bucket update and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hda_probe_ctrl #(
  parameter int TABLE_DEPTH = hda_pkg::TABLE_DEPTH_DEF,
  localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [hda_pkg::INDEX_W-1:0]   index_bits_i,
  // item side
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire hda_pkg::item_t                in_item_i,
  // bucket store
  output logic                               ram_wr_en_o,
  output logic [ADDR_W-1:0]                  ram_wr_addr_o,
  output hda_pkg::bucket_t                   ram_wr_data_o,
  output logic                               ram_rd_en_o,
  output logic [ADDR_W-1:0]                  ram_rd_addr_o,
  input  wire hda_pkg::bucket_t              ram_rd_data_i,
  // result side
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output hda_pkg::result_t                   out_data_o
);

  localparam int DEPTH_LOG2 = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int CAP_BITS   = (DEPTH_LOG2 < hda_pkg::MAX_INDEX_BITS) ?
                              DEPTH_LOG2 : hda_pkg::MAX_INDEX_BITS;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_PROBE  = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [ADDR_W-1:0]           clr_addr_q;
  logic [63:0]                 key_q;
  logic [31:0]                 num_q;
  logic [31:0]                 weight_q;
  logic [ADDR_W-1:0]           mask_q;
  logic [ADDR_W-1:0]           pos_q;
  logic [ADDR_W-1:0]           probe_cnt_q;
  hda_pkg::bucket_t            bucket_q;
  logic                        opened_q;
  logic                        full_q;
  hda_pkg::bucket_t            upd_q, upd_d;
  logic [31:0]                 prev_last_q;
  logic [hda_pkg::GROUPS_W-1:0] groups_q;
  logic [63:0]                 max_w_q, max_w_d;
  logic [31:0]                 max_c_q, max_c_d;
  logic                        out_valid_q;
  hda_pkg::result_t            out_q, res_d;

  logic [hda_pkg::INDEX_W-1:0] act_bits;
  logic [ADDR_W-1:0]           mask_now;
  logic                        accept;
  logic                        hit;
  logic                        probe_last;
  logic [ADDR_W-1:0]           pos_inc;
  logic                        out_free;
  hda_pkg::bucket_t            base;
  logic [64:0]                 mass_sum;

  // active table size from the register, clamped and capped by depth
  always_comb begin
    act_bits = index_bits_i;
    if (act_bits < hda_pkg::INDEX_W'(hda_pkg::MIN_INDEX_BITS)) begin
      act_bits = hda_pkg::INDEX_W'(hda_pkg::MIN_INDEX_BITS);
    end
    if (act_bits > hda_pkg::INDEX_W'(CAP_BITS)) begin
      act_bits = hda_pkg::INDEX_W'(CAP_BITS);
    end
    for (int i = 0; i < ADDR_W; i++) begin
      mask_now[i] = (i < int'(act_bits));
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // probe decision on the bucket just read
  assign hit        = !ram_rd_data_i.valid || (ram_rd_data_i.key_hash == key_q);
  assign probe_last = (probe_cnt_q == mask_q);
  assign pos_inc    = (pos_q + ADDR_W'(1)) & mask_q;

  // bucket update: fresh cluster or join
  always_comb begin
    base = bucket_q;
    if (opened_q) begin
      base              = '0;
      base.valid        = 1'b1;
      base.key_hash     = key_q;
      base.first_number = num_q;
    end
    mass_sum = {1'b0, base.mass} + {33'd0, weight_q};
    upd_d             = base;
    upd_d.last_number = num_q;
    upd_d.mass        = mass_sum[64] ? '1 : mass_sum[63:0];
    upd_d.size_count  = (&base.size_count) ? base.size_count : base.size_count + 32'd1;
    upd_d.singles     = ((weight_q == 32'd1) && !(&base.singles)) ?
                        base.singles + 32'd1 : base.singles;
  end

  // running maxima and result word
  always_comb begin
    max_w_d = max_w_q;
    max_c_d = max_c_q;
    res_d   = '0;
    if (full_q) begin
      res_d.table_full = 1'b1;
    end else begin
      if (upd_q.mass > max_w_q) begin
        max_w_d = upd_q.mass;
      end
      if (upd_q.size_count > max_c_q) begin
        max_c_d = upd_q.size_count;
      end
      res_d.slot_index    = hda_pkg::SLOT_W'(pos_q);
      res_d.opened_new    = opened_q;
      res_d.link_valid    = !opened_q;
      res_d.link_source   = prev_last_q;
      res_d.leader_number = upd_q.first_number;
      res_d.member_count  = upd_q.size_count;
      res_d.total_weight  = upd_q.mass;
      res_d.single_count  = upd_q.singles;
    end
    res_d.groups_open     = groups_q;
    res_d.heaviest_weight = max_w_d;
    res_d.largest_count   = max_c_d;
  end

  // memory port drive
  always_comb begin
    ram_wr_en_o   = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
    ram_wr_addr_o = (state_q == ST_CLEAR) ? clr_addr_q : pos_q;
    ram_wr_data_o = (state_q == ST_CLEAR) ? '0 : upd_d;
    ram_rd_en_o   = accept || ((state_q == ST_PROBE) && !hit && !probe_last);
    ram_rd_addr_o = (state_q == ST_IDLE) ?
                    (in_item_i.key_hash[ADDR_W-1:0] & mask_now) : pos_inc;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (hit) state_d = ST_UPDATE;
        else if (probe_last) state_d = ST_FINISH;
      end
      ST_UPDATE: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      groups_q    <= '0;
      max_w_q     <= '0;
      max_c_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
      if ((state_q == ST_UPDATE) && opened_q) begin
        groups_q <= groups_q + hda_pkg::GROUPS_W'(1);
      end
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
        max_w_q     <= max_w_d;
        max_c_q     <= max_c_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and probe datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q       <= in_item_i.key_hash;
      num_q       <= in_item_i.item_number;
      weight_q    <= in_item_i.item_weight;
      mask_q      <= mask_now;
      pos_q       <= in_item_i.key_hash[ADDR_W-1:0] & mask_now;
      probe_cnt_q <= '0;
      full_q      <= 1'b0;
    end
    if (state_q == ST_PROBE) begin
      if (hit) begin
        bucket_q <= ram_rd_data_i;
        opened_q <= !ram_rd_data_i.valid;
      end else if (probe_last) begin
        full_q <= 1'b1;
      end else begin
        pos_q       <= pos_inc;
        probe_cnt_q <= probe_cnt_q + ADDR_W'(1);
      end
    end
    if (state_q == ST_UPDATE) begin
      upd_q       <= upd_d;
      prev_last_q <= opened_q ? 32'd0 : bucket_q.last_number;
    end
    if ((state_q == ST_FINISH) && out_free) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/core/hda_checker.sv
// ---------------------------------------------------------------------------
// hda_checker
// port level checks on the aggregator's result channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hash_dereplicate_aggregator_macros.svh"

module hda_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [11:0] slot_index_i,
  input wire logic        opened_new_i,
  input wire logic        link_valid_i,
  input wire logic [31:0] link_source_i,
  input wire logic [31:0] member_count_i,
  input wire logic [63:0] total_weight_i,
  input wire logic [31:0] largest_count_i,
  input wire logic [63:0] heaviest_weight_i,
  input wire logic        table_full_i
);

  // a stalled result transaction keeps its payload
  `HDA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(total_weight_i) && $stable(member_count_i) && $stable(slot_index_i), "result changed while stalled")

  // a dropped item reports no bucket and no link
  `HDA_ASSERT_NOW(a_full_empty, clk_i, rst_ni, out_valid_i && table_full_i, !opened_new_i && !link_valid_i && (slot_index_i == 12'd0) && (link_source_i == 32'd0), "dropped item carries bucket data")

  // every stored item either opens or joins a cluster
  `HDA_ASSERT_NOW(a_open_or_join, clk_i, rst_ni, out_valid_i && !table_full_i, opened_new_i != link_valid_i, "open and link flags disagree")

  // cluster totals never exceed the running maxima
  `HDA_ASSERT_NOW(a_max_bound, clk_i, rst_ni, out_valid_i && !table_full_i, (member_count_i <= largest_count_i) && (total_weight_i <= heaviest_weight_i), "cluster total above running maximum")

endmodule

bind hash_dereplicate_aggregator hda_checker u_hda_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .slot_index_i      (out_o.slot_index),
  .opened_new_i      (out_o.opened_new),
  .link_valid_i      (out_o.link_valid),
  .link_source_i     (out_o.link_source),
  .member_count_i    (out_o.member_count),
  .total_weight_i    (out_o.total_weight),
  .largest_count_i   (out_o.largest_count),
  .heaviest_weight_i (out_o.heaviest_weight),
  .table_full_i      (out_o.table_full)
);

`default_nettype wire

>>> test/hash_dereplicate_aggregator_tb.sv
// ---------------------------------------------------------------------------
// hash_dereplicate_aggregator_tb
// self-checking bench for the hash dereplicate aggregator: items go in
// through a bursty sender, results come out through a stalling receiver, and
// every result is compared field by field with a cycle-free model of the
// linear probing bucket store kept inside the bench
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hash_dereplicate_aggregator_tb;

  localparam int          DEPTH        = hda_pkg::TABLE_DEPTH_DEF;
  localparam int          SETTLE       = 8;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          POOL_SIZE    = 8;
  localparam int          ROUND_ITEMS  = 68;
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  // one bucket of the bench's own store
  typedef struct packed {
    logic        used;
    logic [63:0] key;
    logic [31:0] first;
    logic [31:0] last;
    logic [63:0] mass;
    logic [31:0] members;
    logic [31:0] singles;
  } cluster_rec_t;

  logic clk_i;
  logic rst_ni;

  hda_cfg_if cfg_bus ();
  hda_in_if  item_bus ();
  hda_out_if result_bus ();

  hash_dereplicate_aggregator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (item_bus),
    .out_o (result_bus)
  );

  // model state
  cluster_rec_t                 cluster_store [DEPTH];
  logic [hda_pkg::GROUPS_W-1:0] open_groups;
  logic [63:0]                  heaviest_seen;
  logic [31:0]                  largest_seen;
  logic [hda_pkg::INDEX_W-1:0]  index_cfg;

  hda_pkg::result_t cluster_update_q [$];
  logic [63:0]      known_hashes [$];

  int               fail_count;
  int unsigned      cycle_count;
  int unsigned      burst_left;
  int unsigned      seq_no;
  logic             hold_active;
  logic [15:0]      ready_pattern;
  logic [5:0]       rx_tick;
  hda_pkg::result_t seen_res;
  hda_pkg::result_t want_res;
  event             hold_off_req;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // model of the bucket store
  // ---------------------------------------------------------------------------

  // buckets in use for the current index_bits
  function automatic int unsigned active_span();
    int unsigned bits;
    int unsigned span;
    bits = 32'(index_cfg);
    if (bits < hda_pkg::MIN_INDEX_BITS) bits = hda_pkg::MIN_INDEX_BITS;
    if (bits > hda_pkg::MAX_INDEX_BITS) bits = hda_pkg::MAX_INDEX_BITS;
    span = 1 << bits;
    while (span > DEPTH && span > 1) span = span >> 1;
    return span;
  endfunction

  // probe, merge and report one item
  function automatic hda_pkg::result_t predict_cluster_update(logic [63:0] h,
                                                              logic [31:0] num,
                                                              logic [31:0] w);
    hda_pkg::result_t r;
    int unsigned      span;
    int unsigned      pos;
    int unsigned      n;
    bit               hit;
    logic [31:0]      prev_last;
    bit               opened;
    span = active_span();
    pos  = h[31:0] & (span - 1);
    hit  = 1'b0;
    r    = '0;
    for (n = 0; n < span; n++) begin
      if (!cluster_store[pos].used || cluster_store[pos].key == h) begin
        hit = 1'b1;
        break;
      end
      pos = (pos + 1) & (span - 1);
    end
    // nothing free and nothing matching: item dropped
    if (!hit) begin
      r.groups_open     = open_groups;
      r.heaviest_weight = heaviest_seen;
      r.largest_count   = largest_seen;
      r.table_full      = 1'b1;
      return r;
    end
    opened    = !cluster_store[pos].used;
    prev_last = '0;
    if (opened) begin
      open_groups              = open_groups + 1'b1;
      cluster_store[pos]       = '0;
      cluster_store[pos].used  = 1'b1;
      cluster_store[pos].key   = h;
      cluster_store[pos].first = num;
    end else begin
      prev_last = cluster_store[pos].last;
    end
    // saturating totals
    if (cluster_store[pos].members != '1)
      cluster_store[pos].members = cluster_store[pos].members + 1'b1;
    cluster_store[pos].last = num;
    if (cluster_store[pos].mass > (64'hFFFF_FFFF_FFFF_FFFF - {32'd0, w}))
      cluster_store[pos].mass = '1;
    else
      cluster_store[pos].mass = cluster_store[pos].mass + {32'd0, w};
    if (w == 32'd1 && cluster_store[pos].singles != '1)
      cluster_store[pos].singles = cluster_store[pos].singles + 1'b1;
    if (cluster_store[pos].mass > heaviest_seen) heaviest_seen = cluster_store[pos].mass;
    if (cluster_store[pos].members > largest_seen) largest_seen = cluster_store[pos].members;
    r.slot_index      = pos[hda_pkg::SLOT_W-1:0];
    r.opened_new      = opened;
    r.link_valid      = !opened;
    r.link_source     = prev_last;
    r.leader_number   = cluster_store[pos].first;
    r.member_count    = cluster_store[pos].members;
    r.total_weight    = cluster_store[pos].mass;
    r.single_count    = cluster_store[pos].singles;
    r.groups_open     = open_groups;
    r.heaviest_weight = heaviest_seen;
    r.largest_count   = largest_seen;
    r.table_full      = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // one item transaction, in bursts with random gaps between them
  task automatic send_item(input logic [63:0] h, input logic [31:0] num,
                           input logic [31:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left           = burst_left - 1;
    item_bus.valid       <= 1'b1;
    item_bus.key_hash    <= h;
    item_bus.item_number <= num;
    item_bus.item_weight <= w;
    do @(posedge clk_i); while (!item_bus.ready);
    cluster_update_q.push_back(predict_cluster_update(h, num, w));
  endtask

  // stop offering items and wait for every outstanding result
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    while (cluster_update_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_index_bits(input logic [hda_pkg::INDEX_W-1:0] bits);
    drain_results();
    cfg_bus.valid      <= 1'b1;
    cfg_bus.index_bits <= bits;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    index_cfg = bits;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern, long hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rx_tick == '0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = '1;
        1:       ready_pattern = 16'($urandom);
        2:       ready_pattern = 16'($urandom | $urandom);
        default: ready_pattern = 16'($urandom & $urandom);
      endcase
    end
    rx_tick = rx_tick + 1'b1;
    result_bus.ready <= !hold_active && ready_pattern[rx_tick[3:0]];
  end

  // hold-off counted in cycles
  initial begin : hold_off_proc
    int held;
    hold_active = 1'b0;
    forever begin
      @(hold_off_req);
      hold_active = 1'b1;
      for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
      hold_active = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      seen_res.slot_index      = result_bus.slot_index;
      seen_res.opened_new      = result_bus.opened_new;
      seen_res.link_valid      = result_bus.link_valid;
      seen_res.link_source     = result_bus.link_source;
      seen_res.leader_number   = result_bus.leader_number;
      seen_res.member_count    = result_bus.member_count;
      seen_res.total_weight    = result_bus.total_weight;
      seen_res.single_count    = result_bus.single_count;
      seen_res.groups_open     = result_bus.groups_open;
      seen_res.heaviest_weight = result_bus.heaviest_weight;
      seen_res.largest_count   = result_bus.largest_count;
      seen_res.table_full      = result_bus.table_full;
      if (cluster_update_q.size() == 0) begin
        report_mismatch("result with nothing outstanding, slot",
                        64'(seen_res.slot_index), 64'd0);
      end else begin
        want_res = cluster_update_q.pop_front();
        if (seen_res.slot_index !== want_res.slot_index)
          report_mismatch("slot_index", 64'(seen_res.slot_index),
                          64'(want_res.slot_index));
        if (seen_res.opened_new !== want_res.opened_new)
          report_mismatch("opened_new", 64'(seen_res.opened_new),
                          64'(want_res.opened_new));
        if (seen_res.link_valid !== want_res.link_valid)
          report_mismatch("link_valid", 64'(seen_res.link_valid),
                          64'(want_res.link_valid));
        if (seen_res.link_source !== want_res.link_source)
          report_mismatch("link_source", 64'(seen_res.link_source),
                          64'(want_res.link_source));
        if (seen_res.leader_number !== want_res.leader_number)
          report_mismatch("leader_number", 64'(seen_res.leader_number),
                          64'(want_res.leader_number));
        if (seen_res.member_count !== want_res.member_count)
          report_mismatch("member_count", 64'(seen_res.member_count),
                          64'(want_res.member_count));
        if (seen_res.total_weight !== want_res.total_weight)
          report_mismatch("total_weight", seen_res.total_weight, want_res.total_weight);
        if (seen_res.single_count !== want_res.single_count)
          report_mismatch("single_count", 64'(seen_res.single_count),
                          64'(want_res.single_count));
        if (seen_res.groups_open !== want_res.groups_open)
          report_mismatch("groups_open", 64'(seen_res.groups_open),
                          64'(want_res.groups_open));
        if (seen_res.heaviest_weight !== want_res.heaviest_weight)
          report_mismatch("heaviest_weight", seen_res.heaviest_weight,
                          want_res.heaviest_weight);
        if (seen_res.largest_count !== want_res.largest_count)
          report_mismatch("largest_count", 64'(seen_res.largest_count),
                          64'(want_res.largest_count));
        if (seen_res.table_full !== want_res.table_full)
          report_mismatch("table_full", 64'(seen_res.table_full),
                          64'(want_res.table_full));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] fresh_hash();
    logic [63:0] h;
    h = {$urandom, $urandom};
    known_hashes.push_back(h);
    return h;
  endfunction

  // mostly in input order, now and then an arbitrary number
  function automatic logic [31:0] next_number();
    if ($urandom_range(0, 15) == 0) return $urandom;
    seq_no = seq_no + 1;
    return seq_no;
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1, 2:    return 32'd1;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom;
      default: return $urandom_range(2, 500);
    endcase
  endfunction

  // a round of items from a pool of hashes; odd entries share their start
  // bucket with the previous one so that probing and wrapping happen
  task automatic send_pool_round(input int count);
    logic [63:0] pool [POOL_SIZE];
    logic [63:0] h;
    int          i;
    for (i = 0; i < POOL_SIZE; i++) begin
      pool[i] = fresh_hash();
      if (i % 2 == 1) pool[i][hda_pkg::SLOT_W-1:0] = pool[i-1][hda_pkg::SLOT_W-1:0];
    end
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        7, 8:    h = fresh_hash();
        9:       h = known_hashes[$urandom_range(0, known_hashes.size() - 1)];
        default: h = pool[$urandom_range(0, POOL_SIZE - 1)];
      endcase
      send_item(h, next_number(), pick_weight());
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, joins, zero-mass clusters, probing and wrap at full size
  task automatic test_first_items();
    send_item(64'h0, 32'h0, 32'h0);
    // cluster with zero mass is still occupied and is joined
    send_item(64'h0, 32'h1, 32'h0);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(64'hFFFF_FFFF_FFFF_FFFF, 32'h5, 32'hFFFF_FFFF);
    // same start bucket as hash 0, probes on
    send_item(64'h1000, 32'h6, 32'h1);
    send_item(64'h2000, 32'h7, 32'h1);
    send_item(64'h1000, 32'h8, 32'h1);
    // starts at the last bucket and wraps past the front ones
    send_item(64'hFFFF_FFFF_FFFF_EFFF, 32'h9, 32'h8000_0000);
    known_hashes.push_back(64'h0);
    known_hashes.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    known_hashes.push_back(64'h1000);
  endtask

  // out of range index_bits and a size change with the store kept
  task automatic test_index_clamp();
    write_index_bits(4'd0);
    send_item(64'h0123_4567_89AB_CDE7, 32'hA, 32'h3);
    send_item(64'h0, 32'hB, 32'h1);
    write_index_bits(4'd15);
    send_item(64'h0BAD_F00D_0000_0ABC, 32'hC, 32'h2);
    // same hash now starts at a bucket outside the old range
    send_item(64'h0123_4567_89AB_CDE7, 32'hD, 32'h4);
  endtask

  // fill the smallest table, then drop and still join
  task automatic test_table_full();
    int i;
    write_index_bits(4'd3);
    for (i = 0; i < 14; i++) send_item(fresh_hash(), next_number(), pick_weight());
    send_item(64'h0, next_number(), 32'h1);
    send_item(fresh_hash(), next_number(), 32'h1);
  endtask

  // receiver holds off while items keep coming
  task automatic test_backpressure();
    write_index_bits(4'd8);
    -> hold_off_req;
    send_pool_round(40);
  endtask

  // random rounds over several table sizes
  task automatic test_random_rounds();
    logic [hda_pkg::INDEX_W-1:0] sizes [6];
    int                          r;
    sizes = '{4'd5, 4'd3, 4'd13, 4'd6, 4'd10, 4'd15};
    for (r = 0; r < 6; r++) begin
      write_index_bits(sizes[r]);
      send_pool_round(ROUND_ITEMS);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    int i;
    for (i = 0; i < DEPTH; i++) cluster_store[i] = '0;
    open_groups   = '0;
    heaviest_seen = '0;
    largest_seen  = '0;
    index_cfg     = hda_pkg::INDEX_BITS_RESET;
    fail_count    = 0;
    burst_left    = 0;
    seq_no        = 32'd100;
    rx_tick       = '0;
    ready_pattern = '1;

    rst_ni               = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index_bits   = '0;
    item_bus.valid       = 1'b0;
    item_bus.key_hash    = '0;
    item_bus.item_number = '0;
    item_bus.item_weight = '0;
    result_bus.ready     = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_first_items();
    test_index_clamp();
    test_table_full();
    test_backpressure();
    test_random_rounds();
    drain_results();

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // cycle limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
